// ----- sv/epms_pkg.sv -----
// Package for the exact pattern match scanner.
// Holds the shared widths, register indexes and packed types; depends on nothing.
`timescale 1ns / 1ps

package epms_pkg;

    // Widths that the register map and the stream fields fix
    localparam int unsigned ByteW      = 8;
    localparam int unsigned PatBytes   = 16;
    localparam int unsigned LenW       = 5;
    localparam int unsigned CountW     = 21;
    localparam int unsigned OutW       = 20;
    localparam int unsigned CfgDataW   = 64;
    localparam int unsigned CfgIndexW  = 2;

    // Reset value of the per-text match limit
    localparam logic [CountW-1:0] MaxMatchesReset = CountW'(1048576);

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2,
        CFG_MAX_MATCHES  = 2'd3
    } cfg_index_t;

    // Pattern bytes, byte 0 in the lowest lane
    typedef logic [PatBytes-1:0][ByteW-1:0] pattern_t;

    // Control that every window cell sees
    typedef struct packed {
        logic            shift_en;
        logic [LenW-1:0] pat_len;
    } cell_ctrl_t;

endpackage

// ----- sv/exact_pattern_match_scanner.sv -----
// Top level of the exact pattern match scanner: config registers, cell chain, match stage.
// Depends on epms_pkg and epms_cell.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake          Payload (low bit up)
// s_        in   s_tvalid/s_tready  s_tdata: text_byte[7:0]; s_tlast: last_of_text
// m_        out  m_tvalid/m_tready  m_tdata: match_start[19:0], match_ordinal[39:20]
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One text byte is taken per cycle while s_tready is high. A byte enters the cell chain on
// acceptance; its match is resolved in the compare stage and lands in the output register
// once that register is free. Reset (aresetn low, synchronous) clears the counters, valids
// and config registers. A stall on m_tready holds the output and the compare stage;
// s_tready drops only while both are full.

module exact_pattern_match_scanner #(
    parameter int unsigned        MAX_PATTERN = 16,
    parameter longint unsigned    MAX_TEXT    = 1048576
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // text_byte[7:0]
    input  logic                              s_tlast,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // match_start, match_ordinal

    input  logic                              cfg_wr_en,
    input  logic [epms_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [epms_pkg::CfgDataW-1:0]     cfg_wdata
);

    localparam int unsigned PosW     = $clog2(MAX_TEXT + 1);
    localparam logic [PosW-1:0] MaxTextPos = PosW'(MAX_TEXT);
    localparam int unsigned LimLen   = (MAX_PATTERN < epms_pkg::PatBytes) ?
                                       MAX_PATTERN : epms_pkg::PatBytes;

    // Configuration registers
    logic [epms_pkg::CfgDataW-1:0] pattern_low_bytes_reg;
    logic [epms_pkg::CfgDataW-1:0] pattern_high_bytes_reg;
    logic [epms_pkg::LenW-1:0]     pattern_length_reg;
    logic [epms_pkg::CountW-1:0]   max_matches_reg;

    // Compare stage
    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic                          a_last_reg;
    logic                          a_ok_reg;
    logic [epms_pkg::OutW-1:0]     a_start_reg;
    logic [PosW-1:0]               text_position_reg;
    logic [PosW-1:0]               text_position_next;

    // Match stage and output
    logic [epms_pkg::CountW-1:0]   matches_reported_reg;
    logic [epms_pkg::CountW-1:0]   matches_reported_next;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [epms_pkg::OutW-1:0]     match_start_reg;
    logic [epms_pkg::OutW-1:0]     match_ordinal_reg;

    logic                          s_accept;
    logic                          b_go;
    logic                          out_free;
    logic                          len_ok;
    logic                          pos_ok;
    logic                          hit;
    logic [epms_pkg::OutW-1:0]     start_calc;
    epms_pkg::pattern_t            pattern;
    epms_pkg::cell_ctrl_t          cell_ctrl;
    logic [MAX_PATTERN-1:0][7:0]   chain;
    logic [MAX_PATTERN-1:0]        eq_bits;

    // Handshake: the compare stage drains whenever the output slot can take its result
    assign out_free = !m_tvalid_reg || m_tready;
    assign b_go     = a_valid_reg && out_free;
    assign s_tready = !a_valid_reg || b_go;
    assign s_accept = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_bytes_reg  <= '0;
            pattern_high_bytes_reg <= '0;
            pattern_length_reg     <= '0;
            max_matches_reg        <= epms_pkg::MaxMatchesReset;
        end else if (cfg_wr_en) begin
            case (epms_pkg::cfg_index_t'(cfg_index))
                epms_pkg::CFG_PATTERN_LOW:  pattern_low_bytes_reg  <= cfg_wdata;
                epms_pkg::CFG_PATTERN_HIGH: pattern_high_bytes_reg <= cfg_wdata;
                epms_pkg::CFG_PATTERN_LEN:
                    pattern_length_reg <= cfg_wdata[epms_pkg::LenW-1:0];
                epms_pkg::CFG_MAX_MATCHES:
                    max_matches_reg <= cfg_wdata[epms_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    assign pattern   = {pattern_high_bytes_reg, pattern_low_bytes_reg};
    assign cell_ctrl = '{shift_en: s_accept, pat_len: pattern_length_reg};

    // Window cells: cell 0 takes the new byte, each later cell its neighbor's
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic [7:0] cell_in;
        if (g == 0) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_link
            assign cell_in = chain[g-1];
        end
        epms_cell #(
            .IDX (g)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .pattern  (pattern),
            .byte_in  (cell_in),
            .byte_out (chain[g]),
            .eq_out   (eq_bits[g])
        );
    end

    // Qualify the incoming word: usable length, enough bytes seen, not past the text limit
    always_comb begin
        len_ok = (pattern_length_reg != '0) &&
                 (32'(pattern_length_reg) <= LimLen);
        pos_ok = (text_position_reg < MaxTextPos) &&
                 ((PosW + 1)'(text_position_reg) + (PosW + 1)'(1) >=
                  (PosW + 1)'(pattern_length_reg));
        start_calc = epms_pkg::OutW'(text_position_reg) + epms_pkg::OutW'(1)
                     - epms_pkg::OutW'(pattern_length_reg);
        text_position_next = text_position_reg;
        if (s_accept) begin
            if (s_tlast) begin
                text_position_next = '0;
            end else if (text_position_reg < MaxTextPos) begin
                text_position_next = text_position_reg + PosW'(1);
            end
        end
        a_valid_next = s_accept ? 1'b1 : (b_go ? 1'b0 : a_valid_reg);
    end

    // Advance the compare stage; the window contents need no clearing since the
    // position guard keeps bytes of an earlier text out of any match
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg       <= 1'b0;
            text_position_reg <= '0;
        end else begin
            a_valid_reg       <= a_valid_next;
            text_position_reg <= text_position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_last_reg  <= s_tlast;
            a_ok_reg    <= len_ok && pos_ok;
            a_start_reg <= start_calc;
        end
    end

    // Resolve the match against the per-text limit
    always_comb begin
        hit = a_ok_reg && (&eq_bits) && (matches_reported_reg < max_matches_reg);
        matches_reported_next = matches_reported_reg;
        m_tvalid_next         = m_tvalid_reg;
        if (b_go) begin
            if (a_last_reg) begin
                matches_reported_next = '0;
            end else if (hit) begin
                matches_reported_next = matches_reported_reg + epms_pkg::CountW'(1);
            end
            m_tvalid_next = hit;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matches_reported_reg <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            matches_reported_reg <= matches_reported_next;
            m_tvalid_reg         <= m_tvalid_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (b_go && hit) begin
            match_start_reg   <= a_start_reg;
            match_ordinal_reg <= matches_reported_reg[epms_pkg::OutW-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {match_ordinal_reg, match_start_reg};

endmodule

// ----- sv/epms_cell.sv -----
// One window cell of the pattern scanner: holds one text byte and its compare bit.
// Depends on epms_pkg for widths, the pattern type and the control struct.
`timescale 1ns / 1ps

module epms_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                         aclk,
    input  epms_pkg::cell_ctrl_t         ctrl,
    input  epms_pkg::pattern_t           pattern,
    input  logic [epms_pkg::ByteW-1:0]   byte_in,
    output logic [epms_pkg::ByteW-1:0]   byte_out,
    output logic                         eq_out
);

    logic [epms_pkg::ByteW-1:0] byte_reg;
    logic [epms_pkg::ByteW-1:0] byte_next;
    logic                       eq_reg;
    logic                       eq_next;
    logic                       active;
    logic [6:0]                 sel;
    logic [epms_pkg::ByteW-1:0] pat_byte;

    // This cell holds window slot IDX, which lines up with pattern byte len-1-IDX
    always_comb begin
        active    = (32'(ctrl.pat_len) > IDX);
        sel       = {2'b00, ctrl.pat_len} - 7'(IDX + 1);
        pat_byte  = pattern[sel[3:0]];
        byte_next = byte_in;
        eq_next   = active ? (byte_in == pat_byte) : 1'b1;
    end

    // Take the incoming byte and its compare result on every accepted word
    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            byte_reg <= byte_next;
            eq_reg   <= eq_next;
        end
    end

    assign byte_out = byte_reg;
    assign eq_out   = eq_reg;

endmodule
